// ----- src/elu_pkg.sv -----
package elu_pkg;

  // Field widths.
  localparam int TIME_W   = 32;
  localparam int REG_W    = 31;
  localparam int SPD_W    = 16;
  localparam int SPD_FRAC = 8;

  // The divider dividend is the spacing scaled by the speed fraction.
  localparam int DIV_W = REG_W + SPD_FRAC;

  // The square-root unit takes a 64-bit radicand and yields a 32-bit root.
  localparam int RAD_W  = 2 * TIME_W;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  // Wide signed width for candidate sums.
  localparam int SUM_W = TIME_W + 3;

  // Configuration register indexes.
  localparam logic [1:0] REG_TMAX   = 2'd0;
  localparam logic [1:0] REG_STEP_X = 2'd1;
  localparam logic [1:0] REG_STEP_Y = 2'd2;

  // Update case codes.
  localparam logic [2:0] CASE_Y_ONLY = 3'd0;
  localparam logic [2:0] CASE_X_ONLY = 3'd1;
  localparam logic [2:0] CASE_ONE_Y  = 3'd2;
  localparam logic [2:0] CASE_ONE_X  = 3'd3;
  localparam logic [2:0] CASE_QUAD   = 3'd4;

  // Per-request context that travels alongside the arithmetic chains.
  typedef struct packed {
    logic signed [TIME_W-1:0] cur;
    logic signed [TIME_W-1:0] ny;
    logic signed [TIME_W-1:0] wx;
    logic [TIME_W-1:0]        ad;
    logic                     y_only;
    logic                     x_only;
    logic [REG_W-1:0]         qx;
    logic [REG_W-1:0]         qy;
  } ctx_t;

  // State of one restoring division step, two lanes sharing one divisor.
  typedef struct packed {
    logic [DIV_W-1:0] dx;
    logic [DIV_W-1:0] dy;
    logic [SPD_W-1:0] rx;
    logic [SPD_W-1:0] ry;
    logic [DIV_W-1:0] qx;
    logic [DIV_W-1:0] qy;
    logic [SPD_W-1:0] spd;
  } div_t;

  // State of one digit-by-digit square-root step.
  typedef struct packed {
    logic [RAD_W-1:0]  v;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

endpackage

// ----- src/elu_div_cell.sv -----
module elu_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  elu_pkg::ctx_t in_ctx,
  input  elu_pkg::div_t in_st,
  output logic          out_valid,
  output elu_pkg::ctx_t out_ctx,
  output elu_pkg::div_t out_st
);

  logic                     valid_r;
  elu_pkg::ctx_t            ctx_r;
  elu_pkg::div_t            st_r;
  elu_pkg::div_t            st_nxt;
  logic [elu_pkg::SPD_W:0]  tx;
  logic [elu_pkg::SPD_W:0]  ty;
  logic [elu_pkg::SPD_W:0]  subx;
  logic [elu_pkg::SPD_W:0]  suby;
  logic                     gex;
  logic                     gey;

  // One quotient bit per lane: shift in the next dividend bit and try the divisor.
  always_comb begin
    tx   = {in_st.rx, in_st.dx[elu_pkg::DIV_W-1]};
    ty   = {in_st.ry, in_st.dy[elu_pkg::DIV_W-1]};
    subx = tx - {1'b0, in_st.spd};
    suby = ty - {1'b0, in_st.spd};
    gex  = tx >= {1'b0, in_st.spd};
    gey  = ty >= {1'b0, in_st.spd};
    st_nxt     = in_st;
    st_nxt.dx  = {in_st.dx[elu_pkg::DIV_W-2:0], 1'b0};
    st_nxt.dy  = {in_st.dy[elu_pkg::DIV_W-2:0], 1'b0};
    st_nxt.rx  = gex ? subx[elu_pkg::SPD_W-1:0] : tx[elu_pkg::SPD_W-1:0];
    st_nxt.ry  = gey ? suby[elu_pkg::SPD_W-1:0] : ty[elu_pkg::SPD_W-1:0];
    st_nxt.qx  = {in_st.qx[elu_pkg::DIV_W-2:0], gex};
    st_nxt.qy  = {in_st.qy[elu_pkg::DIV_W-2:0], gey};
  end

  // Valid is control; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ctx_r <= in_ctx;
    st_r  <= st_nxt;
  end

  assign out_valid = valid_r;
  assign out_ctx   = ctx_r;
  assign out_st    = st_r;

endmodule

// ----- src/elu_sqrt_cell.sv -----
module elu_sqrt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  elu_pkg::ctx_t in_ctx,
  input  elu_pkg::sq_t  in_st,
  output logic          out_valid,
  output elu_pkg::ctx_t out_ctx,
  output elu_pkg::sq_t  out_st
);

  logic                      valid_r;
  elu_pkg::ctx_t             ctx_r;
  elu_pkg::sq_t              st_r;
  elu_pkg::sq_t              st_nxt;
  logic [elu_pkg::REM_W-1:0] rem_sh;
  logic [elu_pkg::REM_W-1:0] trial;
  logic                      take;

  // One root bit: bring down two radicand bits and try 4*root+1.
  always_comb begin
    rem_sh = {in_st.rem[elu_pkg::REM_W-3:0], in_st.v[elu_pkg::RAD_W-1 -: 2]};
    trial  = {in_st.root, 2'b01};
    take   = rem_sh >= trial;
    st_nxt.v    = {in_st.v[elu_pkg::RAD_W-3:0], 2'b00};
    st_nxt.rem  = take ? (rem_sh - trial) : rem_sh;
    st_nxt.root = {in_st.root[elu_pkg::ROOT_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ctx_r <= in_ctx;
    st_r  <= st_nxt;
  end

  assign out_valid = valid_r;
  assign out_ctx   = ctx_r;
  assign out_st    = st_r;

endmodule

// ----- src/eikonal_local_update_top.sv -----
// First-order eikonal update for one grid point, fully pipelined.
// Input channel: drive the in_ fields and raise start; the request is taken at
// any clock edge where start is high and busy is low. busy is always low, so a
// new request can be issued in every cycle.
// Result channel: out_valid is high for exactly one cycle with out_new_time and
// out_update_case; the receiver must take it then, it cannot hold results off.
// Throughput is one request per cycle. The pipeline holds the divider chain
// (39 cells, one quotient bit each, both axes in parallel) and the
// square-root chain (32 cells, one root bit each), plus six stages for
// neighbor masking, minima, two multipliers, the radicand, the candidate
// and the final select.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 tmax,
// 1 step_x, 2 step_y) at once; write it only while no request is in flight.
// Reset: synchronous active-low rst_n empties the pipeline and restores
// tmax to 0x7FFFFFFF and both spacings to 1.0.
module eikonal_local_update_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [elu_pkg::TIME_W-1:0] in_current_time,
  input  logic signed [elu_pkg::TIME_W-1:0] in_north_time,
  input  logic signed [elu_pkg::TIME_W-1:0] in_south_time,
  input  logic signed [elu_pkg::TIME_W-1:0] in_east_time,
  input  logic signed [elu_pkg::TIME_W-1:0] in_west_time,
  input  logic                              in_north_known,
  input  logic                              in_south_known,
  input  logic                              in_east_known,
  input  logic                              in_west_known,
  input  logic [elu_pkg::SPD_W-1:0]         in_speed,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [elu_pkg::REG_W-1:0]         cfg_data,
  output logic                              out_valid,
  output logic signed [elu_pkg::TIME_W-1:0] out_new_time,
  output logic [2:0]                        out_update_case
);

  localparam int DIV_N = elu_pkg::DIV_W;
  localparam int SQ_N  = elu_pkg::ROOT_W;

  // Configuration registers.
  logic [elu_pkg::REG_W-1:0] tmax_r;
  logic [elu_pkg::REG_W-1:0] step_x_r;
  logic [elu_pkg::REG_W-1:0] step_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmax_r   <= 31'h7FFF_FFFF;
      step_x_r <= 31'h0001_0000;
      step_y_r <= 31'h0001_0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        elu_pkg::REG_TMAX:   tmax_r   <= cfg_data;
        elu_pkg::REG_STEP_X: step_x_r <= cfg_data;
        elu_pkg::REG_STEP_Y: step_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic                       accept;
  logic [elu_pkg::TIME_W-1:0] tm_ext;
  assign accept = start && !busy;
  assign tm_ext = {1'b0, tmax_r};

  // Neighbor masking: unknown or magnitude equal to tmax reads as tmax.
  function automatic logic signed [elu_pkg::TIME_W-1:0] mask_nb(
    input logic signed [elu_pkg::TIME_W-1:0] t,
    input logic                              known,
    input logic [elu_pkg::TIME_W-1:0]        tm
  );
    logic [elu_pkg::TIME_W-1:0] mag;
    mag = t[elu_pkg::TIME_W-1] ? (~t + 1'b1) : t;
    return (known && mag != tm) ? t : $signed(tm);
  endfunction

  // Stage 0: masked neighbors.
  logic                              v0_r;
  logic signed [elu_pkg::TIME_W-1:0] cur0_r, n0_r, s0_r, e0_r, w0_r;
  logic [elu_pkg::SPD_W-1:0]         spd0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    cur0_r <= in_current_time;
    n0_r   <= mask_nb(in_north_time, in_north_known, tm_ext);
    s0_r   <= mask_nb(in_south_time, in_south_known, tm_ext);
    e0_r   <= mask_nb(in_east_time, in_east_known, tm_ext);
    w0_r   <= mask_nb(in_west_time, in_west_known, tm_ext);
    spd0_r <= in_speed;
  end

  // Stage 1: axis minima, axis presence, difference magnitude, divider load.
  logic                              v1_r;
  elu_pkg::ctx_t                     ctx1_r;
  elu_pkg::ctx_t                     ctx1_nxt;
  elu_pkg::div_t                     div1_r;
  elu_pkg::div_t                     div1_nxt;
  logic signed [elu_pkg::TIME_W:0]   d1;

  always_comb begin
    ctx1_nxt.cur    = cur0_r;
    ctx1_nxt.ny     = (n0_r < s0_r) ? n0_r : s0_r;
    ctx1_nxt.wx     = (w0_r < e0_r) ? w0_r : e0_r;
    ctx1_nxt.y_only = (w0_r == $signed(tm_ext)) && (e0_r == $signed(tm_ext));
    ctx1_nxt.x_only = (n0_r == $signed(tm_ext)) && (s0_r == $signed(tm_ext));
    d1 = {ctx1_nxt.ny[elu_pkg::TIME_W-1], ctx1_nxt.ny}
       - {ctx1_nxt.wx[elu_pkg::TIME_W-1], ctx1_nxt.wx};
    ctx1_nxt.ad = d1[elu_pkg::TIME_W] ? elu_pkg::TIME_W'(-d1) : d1[elu_pkg::TIME_W-1:0];
    ctx1_nxt.qx = '0;
    ctx1_nxt.qy = '0;
    div1_nxt.dx  = {step_x_r, {elu_pkg::SPD_FRAC{1'b0}}};
    div1_nxt.dy  = {step_y_r, {elu_pkg::SPD_FRAC{1'b0}}};
    div1_nxt.rx  = '0;
    div1_nxt.ry  = '0;
    div1_nxt.qx  = '0;
    div1_nxt.qy  = '0;
    div1_nxt.spd = spd0_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    ctx1_r <= ctx1_nxt;
    div1_r <= div1_nxt;
  end

  // Divider chain: one quotient bit per cell for both spacings.
  logic          div_v   [DIV_N+1];
  elu_pkg::ctx_t div_ctx [DIV_N+1];
  elu_pkg::div_t div_st  [DIV_N+1];

  assign div_v[0]   = v1_r;
  assign div_ctx[0] = ctx1_r;
  assign div_st[0]  = div1_r;

  for (genvar i = 0; i < DIV_N; i++) begin : g_div
    elu_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (div_v[i]),
      .in_ctx    (div_ctx[i]),
      .in_st     (div_st[i]),
      .out_valid (div_v[i+1]),
      .out_ctx   (div_ctx[i+1]),
      .out_st    (div_st[i+1])
    );
  end

  // Stage 2: saturate quotients, square the step term and the difference.
  logic                            v2_r;
  elu_pkg::ctx_t                   ctx2_r;
  elu_pkg::ctx_t                   ctx2_nxt;
  logic [2*elu_pkg::REG_W-1:0]     qq2_r;
  logic [elu_pkg::RAD_W-1:0]       dd2_r;
  elu_pkg::div_t                   div_end;

  assign div_end = div_st[DIV_N];

  always_comb begin
    ctx2_nxt = div_ctx[DIV_N];
    ctx2_nxt.qx = (div_end.qx[DIV_N-1:elu_pkg::REG_W] != '0) ? {elu_pkg::REG_W{1'b1}}
                : div_end.qx[elu_pkg::REG_W-1:0];
    ctx2_nxt.qy = (div_end.qy[DIV_N-1:elu_pkg::REG_W] != '0) ? {elu_pkg::REG_W{1'b1}}
                : div_end.qy[elu_pkg::REG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= div_v[DIV_N];
    end
  end

  always_ff @(posedge clk) begin
    ctx2_r <= ctx2_nxt;
    qq2_r  <= ctx2_nxt.qx * ctx2_nxt.qx;
    dd2_r  <= div_ctx[DIV_N].ad * div_ctx[DIV_N].ad;
  end

  // Stage 3: radicand 2q^2 - d^2, clamped at zero.
  logic                      v3_r;
  elu_pkg::ctx_t             ctx3_r;
  elu_pkg::sq_t              sq3_r;
  logic [elu_pkg::RAD_W-1:0] t2;

  assign t2 = {1'b0, qq2_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    ctx3_r     <= ctx2_r;
    sq3_r.v    <= (t2 > dd2_r) ? (t2 - dd2_r) : '0;
    sq3_r.rem  <= '0;
    sq3_r.root <= '0;
  end

  // Square-root chain: one root bit per cell.
  logic          sq_v   [SQ_N+1];
  elu_pkg::ctx_t sq_ctx [SQ_N+1];
  elu_pkg::sq_t  sq_st  [SQ_N+1];

  assign sq_v[0]   = v3_r;
  assign sq_ctx[0] = ctx3_r;
  assign sq_st[0]  = sq3_r;

  for (genvar j = 0; j < SQ_N; j++) begin : g_sq
    elu_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_v[j]),
      .in_ctx    (sq_ctx[j]),
      .in_st     (sq_st[j]),
      .out_valid (sq_v[j+1]),
      .out_ctx   (sq_ctx[j+1]),
      .out_st    (sq_st[j+1])
    );
  end

  // Stage 4: choose the update formula and form the candidate.
  logic                              v4_r;
  logic [2:0]                        case4_r;
  logic signed [elu_pkg::SUM_W-1:0]  cand4_r;
  logic signed [elu_pkg::TIME_W-1:0] cur4_r;
  elu_pkg::ctx_t                     cx;
  logic signed [elu_pkg::SUM_W-1:0]  ny_e, wx_e, nyq, wxq, quad;
  logic [2:0]                        case_nxt;
  logic signed [elu_pkg::SUM_W-1:0]  cand_nxt;

  always_comb begin
    cx   = sq_ctx[SQ_N];
    ny_e = elu_pkg::SUM_W'(cx.ny);
    wx_e = elu_pkg::SUM_W'(cx.wx);
    nyq  = ny_e + $signed({4'b0, cx.qy});
    wxq  = wx_e + $signed({4'b0, cx.qx});
    quad = (ny_e + wx_e + $signed({3'b0, sq_st[SQ_N].root})) >>> 1;
    priority if (cx.y_only) begin
      case_nxt = elu_pkg::CASE_Y_ONLY;
      cand_nxt = nyq;
    end else if (cx.x_only) begin
      case_nxt = elu_pkg::CASE_X_ONLY;
      cand_nxt = wxq;
    end else if (ny_e < wx_e && nyq < wx_e) begin
      case_nxt = elu_pkg::CASE_ONE_Y;
      cand_nxt = nyq;
    end else if (wx_e < ny_e && wxq < ny_e) begin
      case_nxt = elu_pkg::CASE_ONE_X;
      cand_nxt = wxq;
    end else begin
      case_nxt = elu_pkg::CASE_QUAD;
      cand_nxt = quad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= sq_v[SQ_N];
    end
  end

  always_ff @(posedge clk) begin
    case4_r <= case_nxt;
    cand4_r <= cand_nxt;
    cur4_r  <= cx.cur;
  end

  // Stage 5: keep the smaller of candidate and present time, cap at tmax.
  logic                              v5_r;
  logic signed [elu_pkg::TIME_W-1:0] time5_r;
  logic [2:0]                        case5_r;
  logic signed [elu_pkg::SUM_W-1:0]  cur_e, res;

  always_comb begin
    cur_e = elu_pkg::SUM_W'(cur4_r);
    res   = (cand4_r < cur_e) ? cand4_r : cur_e;
    if (res > $signed({4'b0, tmax_r})) begin
      res = $signed({4'b0, tmax_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    time5_r <= res[elu_pkg::TIME_W-1:0];
    case5_r <= case4_r;
  end

  assign out_valid       = v5_r;
  assign out_new_time    = time5_r;
  assign out_update_case = case5_r;

  // A result never exceeds tmax.
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_new_time <= $signed({1'b0, tmax_r})))
    else $error("result above tmax");

  // Only the five defined update cases appear.
  a_case: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_update_case <= elu_pkg::CASE_QUAD))
    else $error("undefined update case");

  // Every square-root chain output is followed by a result through stages 4 and 5.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    sq_v[SQ_N] |=> ##1 out_valid)
    else $error("result lost in final stages");

  // The x-only case only arises when the x axis is the only one present.
  a_axis: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && case4_r == elu_pkg::CASE_X_ONLY |-> $past(!cx.y_only && cx.x_only))
    else $error("axis case mismatch");

endmodule
